@@ rtl/csvt_pkg.sv @@
package csvt_pkg;

  localparam logic [7:0] CharQuote   = 8'h22;
  localparam logic [7:0] CharNewline = 8'h0A;

  // Reset value of the delimiter register (comma)
  localparam logic [7:0] DelimReset  = 8'd44;

  // Register index decoded from the APB byte address
  localparam logic RegDelimiter = 1'b0;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_QUOTED = 2'd1,
    MODE_QQUOTE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic [5:0] field_index;
    logic       field_end;
    logic       record_end;
  } tok_t;

endpackage

@@ rtl/csvt_apb.sv @@
module csvt_apb
  import csvt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  delimiter
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegDelimiter);

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DelimReset;
    end else if (wr_en) begin
      delimiter <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegDelimiter) begin
      prdata = {24'd0, delimiter};
    end
  end

endmodule

@@ rtl/csvt_step.sv @@
module csvt_step
  import csvt_pkg::*;
#(
  parameter int MAX_FIELDS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] char_q,
  input  logic [7:0] delimiter,
  output tok_t       res
);

  localparam int IndexCapInt = ((MAX_FIELDS - 1) < 63) ? (MAX_FIELDS - 1) : 63;
  localparam logic [5:0] IndexCap = 6'(IndexCapInt);

  mode_t      mode, mode_next;
  logic [5:0] count, count_next;
  logic       is_delim, is_nl, is_quote;
  logic [5:0] count_inc;

  assign is_delim  = (char_q == delimiter);
  assign is_nl     = (char_q == CharNewline);
  assign is_quote  = (char_q == CharQuote);
  // saturating advance to the next field
  assign count_inc = (count < IndexCap) ? count + 6'd1 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_PLAIN;
      count <= '0;
    end else if (advance) begin
      mode  <= mode_next;
      count <= count_next;
    end
  end

  always_comb begin
    mode_next       = mode;
    count_next      = count;
    res             = '0;
    res.field_index = count;
    unique case (mode)
      MODE_QUOTED: begin
        if (is_quote) begin
          mode_next = MODE_QQUOTE;
        end else begin
          res.data_byte  = char_q;
          res.data_valid = 1'b1;
        end
      end
      MODE_QQUOTE: begin
        if (is_delim) begin
          res.field_end = 1'b1;
          count_next    = count_inc;
          mode_next     = MODE_PLAIN;
        end else if (is_nl) begin
          res.field_end  = 1'b1;
          res.record_end = 1'b1;
          count_next     = '0;
          mode_next      = MODE_PLAIN;
        end else if (is_quote) begin
          // doubled quote gives one literal quote
          res.data_byte  = char_q;
          res.data_valid = 1'b1;
          mode_next      = MODE_QUOTED;
        end else begin
          mode_next = MODE_PLAIN;
        end
      end
      default: begin
        if (is_delim) begin
          res.field_end = 1'b1;
          count_next    = count_inc;
          mode_next     = MODE_PLAIN;
        end else if (is_nl) begin
          res.field_end  = 1'b1;
          res.record_end = 1'b1;
          count_next     = '0;
          mode_next      = MODE_PLAIN;
        end else if (is_quote) begin
          mode_next = MODE_QUOTED;
        end else begin
          res.data_byte  = char_q;
          res.data_valid = 1'b1;
        end
      end
    endcase
  end

endmodule

@@ rtl/csvt_outreg.sv @@
module csvt_outreg
  import csvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  tok_t       res,
  output logic       free,
  output logic       tok_valid,
  input  logic       tok_ready,
  output logic [7:0] data_byte,
  output logic       data_valid,
  output logic [5:0] field_index,
  output logic       field_end,
  output logic       record_end
);

  tok_t held;

  assign free = !tok_valid || tok_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (free) begin
      tok_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      held <= res;
    end
  end

  assign data_byte   = held.data_byte;
  assign data_valid  = held.data_valid;
  assign field_index = held.field_index;
  assign field_end   = held.field_end;
  assign record_end  = held.record_end;

endmodule

@@ rtl/csv_field_tokenizer.sv @@
// CSV field tokenizer: takes one byte of CSV text per item on the char
// channel and returns one token item per input byte on the tok channel,
// in order. A token carries the content byte (data_valid set when the
// byte is field content), the index of the field it belongs to, and
// field_end / record_end flags for a delimiter or newline outside quotes.
// Quoted fields follow the usual rules: a doubled quote gives one quote,
// and a newline right after a closing quote ends the record. The field
// index saturates at min(MAX_FIELDS-1, 63). The delimiter (reset ',') is
// set over APB at byte address 0 and should only be changed while idle.
// Throughput is one item per clock while tok_ready stays high; each item
// passes the input register, then the quote-mode update and decode into
// the result register. The result register frees in the same cycle its
// item is taken, so a stalled output holds at most two items in flight.
module csv_field_tokenizer
  import csvt_pkg::*;
#(
  parameter int MAX_FIELDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // character input
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  char_in,
  // token output
  output logic        tok_valid,
  input  logic        tok_ready,
  output logic [7:0]  data_byte,
  output logic        data_valid,
  output logic [5:0]  field_index,
  output logic        field_end,
  output logic        record_end
);

  logic [7:0] delimiter;
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       out_free;
  logic       advance;
  tok_t       step_res;

  // item moves from the input register into the result register
  assign advance    = s1_valid && out_free;
  assign char_ready = !s1_valid || out_free;

  csvt_apb u_apb (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .delimiter (delimiter)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_ready) begin
      s1_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      s1_char <= char_in;
    end
  end

  // quote-mode state and field counter, updated once per item
  csvt_step #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .char_q    (s1_char),
    .delimiter (delimiter),
    .res       (step_res)
  );

  csvt_outreg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (s1_valid),
    .res         (step_res),
    .free        (out_free),
    .tok_valid   (tok_valid),
    .tok_ready   (tok_ready),
    .data_byte   (data_byte),
    .data_valid  (data_valid),
    .field_index (field_index),
    .field_end   (field_end),
    .record_end  (record_end)
  );

endmodule
